// ===== design/yppu_pkg.sv =====
`default_nettype none
package yppu_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 20;
  localparam int LUMA_W  = 20;
  localparam int CHROMA_W = 19;
  localparam int PHASE_W = 4;
  localparam int PLANE_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 20;

  // Largest frame the buffer holds; larger sizes saturate here
  localparam logic [LUMA_W-1:0] MAX_LUMA = LUMA_W'(524288);
  localparam logic [LUMA_W-1:0] LUMA_RESET = LUMA_W'(442368);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_411    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_PIXELS = 1'b1;

  // Plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  // Last phase of each byte group
  localparam logic [PHASE_W-1:0] LAST_PHASE_422 = 4'd3;
  localparam logic [PHASE_W-1:0] LAST_PHASE_411 = 4'd11;

  // Settled configuration shared by the stages
  typedef struct packed {
    logic              mode_411;
    logic [LUMA_W-1:0] luma;     // saturated luma size, also the U plane base
    logic [ADDR_W-1:0] v_base;   // start of the V plane
  } cfg_t;

  // V plane base for a given size and mode
  function automatic logic [ADDR_W-1:0] v_base_of(input logic mode_411,
                                                  input logic [LUMA_W-1:0] luma);
    logic [ADDR_W-1:0] chroma;
    begin
      chroma = mode_411 ? ADDR_W'(luma >> 2) : ADDR_W'(luma >> 1);
      return ADDR_W'(luma) + chroma;
    end
  endfunction

  // Plane of a byte at a given phase of its group
  function automatic logic [PLANE_W-1:0] plane_of(input logic mode_411,
                                                  input logic [PHASE_W-1:0] phase);
    logic [PLANE_W-1:0] p;
    begin
      p = PLANE_Y;
      if (mode_411) begin
        case (phase)
          4'd0, 4'd4: p = PLANE_U;
          4'd2, 4'd6: p = PLANE_V;
          default:    p = PLANE_Y;
        endcase
      end else begin
        case (phase[1:0])
          2'd1:    p = PLANE_U;
          2'd3:    p = PLANE_V;
          default: p = PLANE_Y;
        endcase
      end
      return p;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/yppu_cfg.sv =====
`default_nettype none
module yppu_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [yppu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [yppu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output yppu_pkg::cfg_t                          cfg,
  output logic                                    restart
);

  logic                          mode_411;
  logic [yppu_pkg::LUMA_W-1:0]   luma;
  logic [yppu_pkg::ADDR_W-1:0]   v_base;
  logic [yppu_pkg::LUMA_W-1:0]   luma_sat;

  // Clamp the incoming size to the buffer limit
  always_comb begin
    luma_sat = cfg_data[yppu_pkg::LUMA_W-1:0];
    if (luma_sat > yppu_pkg::MAX_LUMA) luma_sat = yppu_pkg::MAX_LUMA;
  end

  // Hold settled values; recompute the V base on every write
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_411 <= 1'b0;
      luma     <= yppu_pkg::LUMA_RESET;
      v_base   <= yppu_pkg::v_base_of(1'b0, yppu_pkg::LUMA_RESET);
      restart  <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          yppu_pkg::REG_MODE_411: begin
            mode_411 <= cfg_data[0];
            v_base   <= yppu_pkg::v_base_of(cfg_data[0], luma);
            restart  <= 1'b1;
          end
          yppu_pkg::REG_LUMA_PIXELS: begin
            luma    <= luma_sat;
            v_base  <= yppu_pkg::v_base_of(mode_411, luma_sat);
            restart <= 1'b1;
          end
          default: restart <= 1'b0;
        endcase
      end
    end
  end

  assign cfg.mode_411 = mode_411;
  assign cfg.luma     = luma;
  assign cfg.v_base   = v_base;

endmodule
`default_nettype wire

// ===== design/yppu_map.sv =====
`default_nettype none
module yppu_map (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire yppu_pkg::cfg_t                   cfg,
  input  wire logic                             restart,
  input  wire logic                             advance,
  output logic [yppu_pkg::PLANE_W-1:0]          plane,
  output logic [yppu_pkg::ADDR_W-1:0]           addr,
  output logic                                  last
);

  logic [yppu_pkg::PHASE_W-1:0]   phase;
  logic [yppu_pkg::LUMA_W-1:0]    luma_written;
  logic [yppu_pkg::CHROMA_W-1:0]  u_written;
  logic [yppu_pkg::CHROMA_W-1:0]  v_written;

  logic [yppu_pkg::PHASE_W-1:0]   phase_eff;
  logic [yppu_pkg::PHASE_W-1:0]   last_phase;
  logic [yppu_pkg::LUMA_W:0]      luma_next;
  logic                           group_end;

  // Pick plane and address for the byte at the current phase
  always_comb begin
    last_phase = cfg.mode_411 ? yppu_pkg::LAST_PHASE_411 : yppu_pkg::LAST_PHASE_422;
    phase_eff  = (phase > last_phase) ? '0 : phase;
    plane      = yppu_pkg::plane_of(cfg.mode_411, phase_eff);
    luma_next  = {1'b0, luma_written};
    case (plane)
      yppu_pkg::PLANE_Y: begin
        addr      = luma_written;
        luma_next = {1'b0, luma_written} + 1'b1;
      end
      yppu_pkg::PLANE_U: addr = cfg.luma + yppu_pkg::ADDR_W'(u_written);
      default:           addr = cfg.v_base + yppu_pkg::ADDR_W'(v_written);
    endcase
    group_end = (phase_eff == last_phase);
    last      = group_end && (luma_next >= {1'b0, cfg.luma});
  end

  // Advance the counters once per transfer; clear at frame end or on a write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase        <= '0;
      luma_written <= '0;
      u_written    <= '0;
      v_written    <= '0;
    end else if (advance) begin
      if (last) begin
        phase        <= '0;
        luma_written <= '0;
        u_written    <= '0;
        v_written    <= '0;
      end else begin
        phase <= group_end ? '0 : phase_eff + 1'b1;
        case (plane)
          yppu_pkg::PLANE_Y: luma_written <= luma_next[yppu_pkg::LUMA_W-1:0];
          yppu_pkg::PLANE_U: u_written    <= u_written + 1'b1;
          default:           v_written    <= v_written + 1'b1;
        endcase
      end
    end
  end

  // Frame end leaves every counter at zero
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && last && !restart) |=> (phase == '0 && luma_written == '0 &&
                                       u_written == '0 && v_written == '0))
    else $error("counters not cleared after frame end");

  // A register write restarts the frame
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> (phase == '0 && luma_written == '0))
    else $error("frame not restarted after register write");

  // The frame can only end on the closing byte of a group
  a_last_on_group_end: assert property (@(posedge clk) disable iff (rst)
    last |-> ((cfg.mode_411 && plane == yppu_pkg::PLANE_Y) ||
              (!cfg.mode_411 && plane == yppu_pkg::PLANE_V)))
    else $error("frame end away from group end");

  // In 4:2:2 mode, phase stays inside the 4:2:2 group once a mode change has settled
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (!cfg.mode_411 && !restart) |-> (phase <= yppu_pkg::LAST_PHASE_422))
    else $error("phase beyond 4:2:2 group");

endmodule
`default_nettype wire

// ===== design/yuv_packed_to_planar_unit.sv =====
`default_nettype none
// Datapath: an input register and then a result register; a byte accepted into the input
//   register moves on into the result register when the result register is free.
// Throughput: one byte per cycle while out_ready holds; the plane/address step is a
//   single pass between the two registers, and both registers hand over in the same cycle they refill.
// Reset (rst, synchronous): empties both stages, restarts the frame counters,
//   and loads 4:2:2 mode with a luma size of 442368.
module yuv_packed_to_planar_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [yppu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [yppu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [yppu_pkg::BYTE_W-1:0]       in_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [yppu_pkg::BYTE_W-1:0]            out_byte,
  output logic [yppu_pkg::PLANE_W-1:0]           plane,
  output logic [yppu_pkg::ADDR_W-1:0]            out_addr,
  output logic                                   frame_last
);

  yppu_pkg::cfg_t                      cfg;
  logic                                restart;

  logic                                s1_valid;
  logic [yppu_pkg::BYTE_W-1:0]         s1_byte;
  logic                                s1_advance;
  logic                                out_free;

  logic [yppu_pkg::PLANE_W-1:0]        map_plane;
  logic [yppu_pkg::ADDR_W-1:0]         map_addr;
  logic                                map_last;

  yppu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  yppu_map u_map (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .advance (s1_advance),
    .plane   (map_plane),
    .addr    (map_addr),
    .last    (map_last)
  );

  // Handshake: each stage refills in the cycle it hands over
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte <= in_byte;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_byte   <= s1_byte;
      plane      <= map_plane;
      out_addr   <= map_addr;
      frame_last <= map_last;
    end
  end

endmodule
`default_nettype wire
